@@ rtl/ilp_pkg.sv @@
// Shared types, character codes and helper functions for the integer literal parser.
// No dependencies; every module of the block imports this package.
package ilp_pkg;

    // sizing
    localparam int MAX_CHARS    = 34;
    localparam int VALUE_BITS   = 32;
    localparam int HEX_MAX_BODY = VALUE_BITS / 4 + 2;
    localparam int OCT_MAX_BODY = VALUE_BITS * 3 / 8;
    localparam int COUNT_BITS   = 6;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 40;

    // character codes
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] DIG_OFS  = 8'd48;
    localparam logic [7:0] UPP_OFS  = 8'd55;
    localparam logic [7:0] LOW_OFS  = 8'd87;

    // error codes
    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_EMPTY    = 2'd1,
        ERR_TOO_LONG = 2'd2,
        ERR_BAD_CHAR = 2'd3
    } err_t;

    // one input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } item_t;

    // one result item
    typedef struct packed {
        logic signed [31:0] value;
        err_t               error_code;
    } result_t;

    // hex digit value with a valid flag in the top bit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                t = c - DIG_OFS;
                hex_digit = {1'b1, t[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                t = c - UPP_OFS;
                hex_digit = {1'b1, t[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                t = c - LOW_OFS;
                hex_digit = {1'b1, t[3:0]};
            end else begin
                hex_digit = 5'd0;
            end
        end
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

@@ rtl/ilp_in_stage.sv @@
// Input register of the integer literal parser: holds one accepted item.
// Depends on ilp_pkg.
module ilp_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // [7:0] char_code
    input  logic          s_tlast,    // is_last
    input  logic          take,
    output logic          item_valid,
    output ilp_pkg::item_t item
);
    import ilp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.char_code <= s_tdata;
            item_reg.is_last   <= s_tlast;
        end
    end

endmodule

@@ rtl/ilp_scan.sv @@
// Per-string scan state and the result decision of the integer literal parser.
// Depends on ilp_pkg.
module ilp_scan (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  ilp_pkg::item_t   item,
    input  logic             out_free,
    output logic             take,
    output logic             res_load,
    output ilp_pkg::result_t res
);
    import ilp_pkg::*;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  neg_reg, neg_next;
    logic                  sign_reg, sign_next;
    logic                  long_reg, long_next;
    logic                  bad_reg, bad_next;
    logic [7:0]            first_reg, first_next;
    logic [7:0]            second_reg, second_next;
    logic [VALUE_BITS-1:0] dec_reg, dec_next;
    logic [VALUE_BITS-1:0] pre_reg, pre_next;

    logic [COUNT_BITS:0]   n;
    logic [COUNT_BITS-1:0] body;
    logic [7:0]            c;
    logic [7:0]            d;
    logic [4:0]            hv;
    logic                  is_sign;
    logic [VALUE_BITS-1:0] v;
    err_t                  err;

    // a non-last item never produces a result, so it may always move on
    assign take     = item_valid && (out_free || !item.is_last);
    assign res_load = take && item.is_last;
    assign c        = item.char_code;
    assign d        = c - DIG_OFS;
    assign hv       = hex_digit(c);

    // state update for one character
    always_comb begin
        n           = {1'b0, count_reg} + (COUNT_BITS+1)'(1);
        long_next   = long_reg || (n > (COUNT_BITS+1)'(MAX_CHARS));
        count_next  = n[COUNT_BITS] ? {COUNT_BITS{1'b1}} : n[COUNT_BITS-1:0];
        is_sign     = (n == (COUNT_BITS+1)'(1)) && !item.is_last
                      && (c == CH_MINUS || c == CH_PLUS);
        body        = count_next - COUNT_BITS'(sign_reg);
        neg_next    = neg_reg;
        sign_next   = sign_reg;
        bad_next    = bad_reg;
        first_next  = first_reg;
        second_next = second_reg;
        dec_next    = dec_reg;
        pre_next    = pre_reg;
        if (is_sign) begin
            sign_next = 1'b1;
            neg_next  = (c == CH_MINUS);
        end else begin
            dec_next = (dec_reg << 3) + (dec_reg << 1) + VALUE_BITS'(d);
            if (body == COUNT_BITS'(1)) begin
                first_next = c;
                pre_next   = '0;
            end else if (body == COUNT_BITS'(2)) begin
                second_next = c;
                pre_next    = (c == CH_X || c == CH_B) ? '0 : VALUE_BITS'(d);
            end else if (first_reg == CH_ZERO) begin
                if (second_reg == CH_X) begin
                    if (!hv[4]) bad_next = 1'b1;
                    else pre_next = {pre_reg[VALUE_BITS-5:0], hv[3:0]};
                end else if (second_reg == CH_B) begin
                    if (c != CH_ZERO && c != CH_ONE) bad_next = 1'b1;
                    else pre_next = {pre_reg[VALUE_BITS-2:0], d[0]};
                end else begin
                    if (c < CH_ZERO || c > CH_SEVEN) bad_next = 1'b1;
                    else pre_next = {pre_reg[VALUE_BITS-4:0], d[2:0]};
                end
            end else if (!is_dec(c)) begin
                bad_next = 1'b1;
            end
        end
    end

    // result decision on the last character
    always_comb begin
        err = ERR_OK;
        v   = '0;
        if (long_next) begin
            err = ERR_TOO_LONG;
        end else if (body <= COUNT_BITS'(2)) begin
            if (!is_dec(first_next) || (body == COUNT_BITS'(2) && !is_dec(second_next)))
                err = ERR_BAD_CHAR;
            else
                v = dec_next;
        end else if (first_next == CH_ZERO) begin
            if (second_next == CH_X) begin
                if (body > COUNT_BITS'(HEX_MAX_BODY)) err = ERR_TOO_LONG;
                else if (bad_next) err = ERR_BAD_CHAR;
                else v = pre_next;
            end else if (second_next == CH_B) begin
                if (bad_next) err = ERR_BAD_CHAR;
                else v = pre_next;
            end else begin
                if (body > COUNT_BITS'(OCT_MAX_BODY)) err = ERR_TOO_LONG;
                else if (bad_next || second_next < CH_ZERO || second_next > CH_SEVEN)
                    err = ERR_BAD_CHAR;
                else v = pre_next;
            end
        end else if (first_next >= CH_ONE && first_next <= CH_NINE) begin
            if (bad_next || !is_dec(second_next)) err = ERR_BAD_CHAR;
            else v = dec_next;
        end else begin
            err = ERR_BAD_CHAR;
        end
        if (err == ERR_OK && neg_next) v = '0 - v;
        res.value      = 32'(v);
        res.error_code = err;
    end

    // scan state, cleared after every last character
    always_ff @(posedge aclk) begin
        if (!aresetn || res_load) begin
            count_reg  <= '0;
            neg_reg    <= 1'b0;
            sign_reg   <= 1'b0;
            long_reg   <= 1'b0;
            bad_reg    <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
            dec_reg    <= '0;
            pre_reg    <= '0;
        end else if (take) begin
            count_reg  <= count_next;
            neg_reg    <= neg_next;
            sign_reg   <= sign_next;
            long_reg   <= long_next;
            bad_reg    <= bad_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            dec_reg    <= dec_next;
            pre_reg    <= pre_next;
        end
    end

endmodule

@@ rtl/ilp_out_stage.sv @@
// Result register of the integer literal parser: holds one result item for the receiver.
// Depends on ilp_pkg.
module ilp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ilp_pkg::result_t res,
    output logic             out_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata    // [31:0] value, [33:32] error_code, [39:34] zero
);
    import ilp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.error_code, res_reg.value};

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

@@ rtl/integer_literal_parser_unit.sv @@
// Integer literal parser, top level: input register, scan logic, result register.
// Depends on ilp_pkg, ilp_in_stage, ilp_scan and ilp_out_stage.
//
// Usage:
//   The s_ channel carries one character per item (s_tdata) and marks the
//   final character of a number string with s_tlast. The m_ channel gives one
//   item per string, on its last character: the signed 32-bit value in
//   m_tdata[31:0] and the error code (0 ok, 2 too long, 3 invalid character)
//   in m_tdata[33:32]; the value is zero whenever the code is not ok.
//   A last character is first taken into the input register; its result is then
//   taken into the result register once that register is free, and m_tvalid
//   rises as the result register loads.
//   Throughput: one item per cycle while the result register is free, set by the
//   single shift-add per accumulator between the two registers.
//   When the receiver stalls, the result register holds; characters that are
//   not last keep flowing, and a last character waits in the input register
//   until the result register frees up.
//   Reset (aresetn low at a clock edge) empties both registers and clears the
//   scan state, so the next character starts a new string.
module integer_literal_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic        s_tlast,    // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [31:0] value, [33:32] error_code, [39:34] zero
);
    import ilp_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    take;
    logic    res_load;
    result_t res;
    logic    out_free;

    // input register
    ilp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // scan state and result decision
    ilp_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_load   (res_load),
        .res        (res)
    );

    // result register
    ilp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
